// ===== rtl/core/mwtg_pkg.sv =====
`timescale 1ns / 1ps

package mwtg_pkg;

    localparam int WAVE_LEN = 64;
    localparam int WAVE_AW  = 6;
    localparam int ROM_LEN  = 74;
    localparam int ROM_AW   = 7;

    localparam logic [7:0] NOTE_BASE  = 8'h21;
    localparam logic [3:0] STAT_ON    = 4'h9;
    localparam logic [3:0] STAT_OFF   = 4'h8;
    localparam logic [7:0] STEP2_FROM = 8'd50;
    localparam logic [7:0] STEP4_FROM = 8'd62;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_BYTE = 1'b1;

    typedef enum logic [2:0] {
        PH_STATUS   = 3'd0,
        PH_ON_NOTE  = 3'd1,
        PH_ON_VEL   = 3'd2,
        PH_OFF_NOTE = 3'd3,
        PH_OFF_VEL  = 3'd4
    } phase_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] midi_byte;
        logic       frame_error;
        logic       wave_select;
    } item_t;

    typedef struct packed {
        logic       pwm_high;
        logic [7:0] duty;
        logic       led_on;
        logic       sounding;
    } result_t;

    typedef struct packed {
        logic               reload;
        logic               shark;
        logic [WAVE_AW-1:0] idx;
        logic [7:0]         pwm_cnt;
        logic               running;
        logic               led;
    } wave_req_t;

    localparam logic [15:0] PERIOD_ROM [ROM_LEN] = '{
        16'h11c1, 16'h10c2, 16'h0fd2, 16'h0eee, 16'h0e18, 16'h0d4d, 16'h0c8e, 16'h0bda,
        16'h0b2f, 16'h0a8f, 16'h09f7, 16'h0968, 16'h08e1, 16'h0861, 16'h07e9, 16'h0777,
        16'h070c, 16'h06a7, 16'h0647, 16'h05ed, 16'h0598, 16'h0547, 16'h04fc, 16'h04b4,
        16'h0470, 16'h0431, 16'h03f4, 16'h03bc, 16'h0386, 16'h0353, 16'h0324, 16'h02f6,
        16'h02cc, 16'h02a4, 16'h027e, 16'h025a, 16'h0238, 16'h0218, 16'h01fa, 16'h01de,
        16'h01c3, 16'h01aa, 16'h0192, 16'h017b, 16'h0166, 16'h0152, 16'h013f, 16'h012d,
        16'h011c, 16'h010c,
        16'h01fa, 16'h01de, 16'h01c3, 16'h01aa, 16'h0192, 16'h017b, 16'h0166, 16'h0152,
        16'h013f, 16'h012d, 16'h011c, 16'h010c,
        16'h01fa, 16'h01de, 16'h01c3, 16'h01aa, 16'h0192, 16'h017b, 16'h0166, 16'h0152,
        16'h013f, 16'h012d, 16'h011c, 16'h010c
    };

    localparam logic [7:0] TRI_TABLE [WAVE_LEN] = '{
        8'd128, 8'd136, 8'd144, 8'd152, 8'd160, 8'd168, 8'd176, 8'd184,
        8'd192, 8'd200, 8'd208, 8'd216, 8'd224, 8'd232, 8'd240, 8'd248,
        8'd255, 8'd248, 8'd240, 8'd232, 8'd224, 8'd216, 8'd208, 8'd200,
        8'd192, 8'd184, 8'd176, 8'd168, 8'd160, 8'd152, 8'd144, 8'd136,
        8'd128, 8'd120, 8'd112, 8'd104, 8'd96,  8'd88,  8'd80,  8'd72,
        8'd64,  8'd56,  8'd48,  8'd40,  8'd32,  8'd24,  8'd16,  8'd8,
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd40,  8'd48,  8'd56,
        8'd64,  8'd72,  8'd80,  8'd88,  8'd96,  8'd104, 8'd112, 8'd120
    };

    localparam logic [7:0] SHARK_TABLE [WAVE_LEN] = '{
        8'd112, 8'd119, 8'd126, 8'd133, 8'd140, 8'd147, 8'd154, 8'd161,
        8'd168, 8'd175, 8'd182, 8'd189, 8'd196, 8'd203, 8'd210, 8'd217,
        8'd255, 8'd248, 8'd240, 8'd232, 8'd224, 8'd216, 8'd208, 8'd200,
        8'd192, 8'd184, 8'd176, 8'd168, 8'd160, 8'd152, 8'd144, 8'd136,
        8'd128, 8'd120, 8'd112, 8'd104, 8'd96,  8'd88,  8'd80,  8'd72,
        8'd64,  8'd56,  8'd48,  8'd40,  8'd32,  8'd24,  8'd16,  8'd8,
        8'd0,   8'd7,   8'd14,  8'd21,  8'd28,  8'd35,  8'd42,  8'd49,
        8'd56,  8'd63,  8'd70,  8'd77,  8'd84,  8'd91,  8'd98,  8'd105
    };

endpackage

// ===== rtl/core/mwtg_ctrl.sv =====
`timescale 1ns / 1ps

module mwtg_ctrl #(
    parameter int TABLE_SIZE = 64,
    parameter int NOTE_COUNT = 74
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  mwtg_pkg::item_t     item,
    output mwtg_pkg::wave_req_t wreq
);
    import mwtg_pkg::*;

    localparam int WPW = $clog2(TABLE_SIZE);

    phase_t         phase_reg, phase_next;
    logic [7:0]     note_reg, note_next;
    logic [15:0]    period_reg, period_next;
    logic           run_reg, run_next;
    logic [15:0]    tone_reg, tone_next;
    logic [7:0]     pwm_reg, pwm_next;
    logic [WPW-1:0] pos_reg, pos_next;
    logic [WPW-1:0] npos_reg, npos_next;
    logic           led_reg, led_next;
    logic           reload;

    logic [7:0]        idx;
    logic              idx_ok;
    logic [ROM_AW-1:0] rom_addr;
    logic              is_byte;
    logic              st_on;
    logic              st_off;
    logic [WPW:0]      step;
    logic [WPW:0]      npos_sum;

    assign is_byte  = (item.req_type == REQ_BYTE);
    assign idx      = item.midi_byte - NOTE_BASE;
    assign idx_ok   = idx < 8'(NOTE_COUNT);
    assign rom_addr = (idx < 8'(ROM_LEN)) ? ROM_AW'(idx) : ROM_AW'(ROM_LEN - 1);
    assign st_on    = !item.frame_error && (item.midi_byte[7:4] == STAT_ON);
    assign st_off   = !item.frame_error && (item.midi_byte[7:4] == STAT_OFF);

    // parser next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (is_byte)
        begin
            case (phase_reg)
                PH_ON_NOTE:  phase_next = PH_ON_VEL;
                PH_ON_VEL:   phase_next = PH_STATUS;
                PH_OFF_NOTE: phase_next = PH_OFF_VEL;
                PH_OFF_VEL:  phase_next = PH_STATUS;
                default:
                begin
                    if (st_on)
                        phase_next = PH_ON_NOTE;
                    else if (st_off)
                        phase_next = PH_OFF_NOTE;
                    else
                        phase_next = PH_STATUS;
                end
            endcase
        end
    end

    always_comb
    begin
        if (note_reg < STEP2_FROM)
            step = (WPW+1)'(1);
        else if (note_reg < STEP4_FROM)
            step = (WPW+1)'(2);
        else
            step = (WPW+1)'(4);
    end

    assign npos_sum = {1'b0, npos_reg} + step;

    // parser actions and timers
    always_comb
    begin
        note_next   = note_reg;
        period_next = period_reg;
        run_next    = run_reg;
        tone_next   = tone_reg;
        pwm_next    = pwm_reg;
        pos_next    = pos_reg;
        npos_next   = npos_reg;
        led_next    = led_reg;
        reload      = 1'b0;
        if (is_byte)
        begin
            case (phase_reg)
                PH_ON_NOTE:
                begin
                    note_next = idx;
                    if (idx_ok)
                    begin
                        period_next = PERIOD_ROM[rom_addr];
                        run_next    = 1'b1;
                    end
                    else
                    begin
                        run_next  = 1'b0;
                        tone_next = '0;
                        pwm_next  = '0;
                    end
                end
                PH_ON_VEL, PH_OFF_NOTE, PH_OFF_VEL:
                begin
                end
                default:
                begin
                    if (st_on)
                        led_next = 1'b1;
                    else if (st_off)
                    begin
                        led_next  = 1'b0;
                        run_next  = 1'b0;
                        tone_next = '0;
                        pwm_next  = '0;
                    end
                end
            endcase
        end
        else if (run_reg)
        begin
            if (tone_reg == period_reg)
            begin
                tone_next = '0;
                pos_next  = npos_reg;
                if (npos_sum >= (WPW+1)'(TABLE_SIZE))
                    npos_next = '0;
                else
                    npos_next = npos_sum[WPW-1:0];
            end
            else
                tone_next = tone_reg + 16'd1;
            pwm_next = pwm_reg + 8'd1;
            reload   = (pwm_reg == 8'hff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_STATUS;
            note_reg   <= '0;
            period_reg <= '0;
            run_reg    <= 1'b0;
            tone_reg   <= '0;
            pwm_reg    <= '0;
            pos_reg    <= '0;
            npos_reg   <= WPW'(1);
            led_reg    <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            note_reg   <= note_next;
            period_reg <= period_next;
            run_reg    <= run_next;
            tone_reg   <= tone_next;
            pwm_reg    <= pwm_next;
            pos_reg    <= pos_next;
            npos_reg   <= npos_next;
            led_reg    <= led_next;
        end
    end

    assign wreq.reload  = reload;
    assign wreq.shark   = item.wave_select;
    assign wreq.idx     = WAVE_AW'(pos_next);
    assign wreq.pwm_cnt = pwm_next;
    assign wreq.running = run_next;
    assign wreq.led     = led_next;

endmodule

// ===== rtl/core/mwtg_wave.sv =====
`timescale 1ns / 1ps

module mwtg_wave (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  mwtg_pkg::wave_req_t wreq,
    output mwtg_pkg::result_t   result
);
    import mwtg_pkg::*;

    logic [7:0] tbl_q;
    logic [7:0] duty_reg;
    logic       reload_reg;
    logic [7:0] pwm_reg;
    logic       run_reg;
    logic       led_reg;
    logic [7:0] duty_cur;

    // wave table read, registered
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (wreq.shark)
                tbl_q <= SHARK_TABLE[wreq.idx];
            else
                tbl_q <= TRI_TABLE[wreq.idx];
        end
    end

    // table data forwarded on the beat that reloads the duty
    assign duty_cur = reload_reg ? tbl_q : duty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg   <= '0;
            reload_reg <= 1'b0;
            pwm_reg    <= '0;
            run_reg    <= 1'b0;
            led_reg    <= 1'b0;
        end
        else if (fire)
        begin
            duty_reg   <= duty_cur;
            reload_reg <= wreq.reload;
            pwm_reg    <= wreq.pwm_cnt;
            run_reg    <= wreq.running;
            led_reg    <= wreq.led;
        end
    end

    assign result.pwm_high = run_reg && (pwm_reg <= duty_cur);
    assign result.duty     = duty_cur;
    assign result.led_on   = led_reg;
    assign result.sounding = run_reg;

endmodule

// ===== rtl/core/midi_wavetable_tone_generator_unit.sv =====
`timescale 1ns / 1ps
// latency: a result is valid on the cycle after its beat is accepted
// throughput: one item per cycle while result_ready is high
// the wave table read (registered memory) is forwarded into the result stage
// reset: parser waits for a status byte, timers stopped and cleared, led off

module midi_wavetable_tone_generator_unit #(
    parameter int TABLE_SIZE = 64,
    parameter int NOTE_COUNT = 74
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  mwtg_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output mwtg_pkg::result_t result
);
    import mwtg_pkg::*;

    logic      fire;
    logic      rvalid_reg;
    wave_req_t wreq;

    assign item_ready   = !rvalid_reg || result_ready;
    assign fire         = item_valid && item_ready;
    assign result_valid = rvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rvalid_reg <= 1'b0;
        else if (item_ready)
            rvalid_reg <= item_valid;
    end

    mwtg_ctrl #(
        .TABLE_SIZE (TABLE_SIZE),
        .NOTE_COUNT (NOTE_COUNT)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item),
        .wreq  (wreq)
    );

    mwtg_wave u_wave (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .wreq   (wreq),
        .result (result)
    );

endmodule

// ===== tb/mwtg_tone_checker.sv =====
`timescale 1ns / 1ps

module mwtg_tone_checker #(
    parameter int TABLE_SIZE = 64,
    parameter int NOTE_COUNT = 74
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  mwtg_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_ready,
    input  mwtg_pkg::result_t result,
    input  logic              run_done,
    output int                mismatches,
    output int                outstanding,
    output int                results_seen,
    output int                wave_steps,
    output int                duty_loads
);
    import mwtg_pkg::*;

    // distinct periods; notes above this range repeat the top octave
    localparam logic [15:0] PERIOD_BASE [50] = '{
        16'h11c1, 16'h10c2, 16'h0fd2, 16'h0eee, 16'h0e18, 16'h0d4d, 16'h0c8e, 16'h0bda,
        16'h0b2f, 16'h0a8f, 16'h09f7, 16'h0968, 16'h08e1, 16'h0861, 16'h07e9, 16'h0777,
        16'h070c, 16'h06a7, 16'h0647, 16'h05ed, 16'h0598, 16'h0547, 16'h04fc, 16'h04b4,
        16'h0470, 16'h0431, 16'h03f4, 16'h03bc, 16'h0386, 16'h0353, 16'h0324, 16'h02f6,
        16'h02cc, 16'h02a4, 16'h027e, 16'h025a, 16'h0238, 16'h0218, 16'h01fa, 16'h01de,
        16'h01c3, 16'h01aa, 16'h0192, 16'h017b, 16'h0166, 16'h0152, 16'h013f, 16'h012d,
        16'h011c, 16'h010c
    };

    phase_t      parse_state;
    logic [7:0]  note_sel;
    logic [15:0] note_period;
    logic        playing;
    logic [15:0] tone_count;
    logic [7:0]  pwm_count;
    logic [7:0]  duty_level;
    int          wave_idx;
    int          wave_idx_next;
    logic        led_lit;
    result_t     expected_outputs [$];
    bit          drain_checked;

    function automatic logic [15:0] period_for(logic [7:0] idx);
        int k;
        k = idx;
        if (k >= 50)
        begin
            k = 38 + (k - 50) % 12;
        end
        return PERIOD_BASE[k];
    endfunction

    function automatic logic [7:0] wave_level(logic shark, int i);
        int v;
        if (i == 16)
        begin
            v = 255;
        end
        else if (i < 16)
        begin
            v = shark ? 112 + 7 * i : 128 + 8 * i;
        end
        else if (i <= 48)
        begin
            v = 128 + 8 * (32 - i);
        end
        else
        begin
            v = shark ? 7 * (i - 48) : 8 * (i - 48);
        end
        return v[7:0];
    endfunction

    task automatic flag(input string msg);
        if (mismatches < 50)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    task automatic clear_prediction();
        parse_state   = PH_STATUS;
        note_sel      = '0;
        note_period   = '0;
        playing       = 1'b0;
        tone_count    = '0;
        pwm_count     = '0;
        duty_level    = '0;
        wave_idx      = 0;
        wave_idx_next = 1;
        led_lit       = 1'b0;
    endtask

    task automatic stop_timers();
        playing    = 1'b0;
        tone_count = '0;
        pwm_count  = '0;
    endtask

    task automatic parse_midi(input logic [7:0] b, input logic ferr);
        logic [7:0] idx;
        case (parse_state)
            PH_ON_NOTE:
            begin
                idx      = b - NOTE_BASE;
                note_sel = idx;
                if (idx < NOTE_COUNT)
                begin
                    note_period = period_for(idx);
                    playing     = 1'b1;
                end
                else
                begin
                    stop_timers();
                end
                parse_state = PH_ON_VEL;
            end
            PH_ON_VEL, PH_OFF_VEL:
            begin
                parse_state = PH_STATUS;
            end
            PH_OFF_NOTE:
            begin
                parse_state = PH_OFF_VEL;
            end
            default:
            begin
                parse_state = PH_STATUS;
                if (!ferr && b[7:4] == STAT_ON)
                begin
                    led_lit     = 1'b1;
                    parse_state = PH_ON_NOTE;
                end
                else if (!ferr && b[7:4] == STAT_OFF)
                begin
                    led_lit = 1'b0;
                    stop_timers();
                    parse_state = PH_OFF_NOTE;
                end
            end
        endcase
    endtask

    task automatic run_tick(input logic shark);
        int stride;
        if (playing)
        begin
            if (tone_count == note_period)
            begin
                tone_count = '0;
                wave_idx   = wave_idx_next;
                if (note_sel < STEP2_FROM)
                begin
                    stride = 1;
                end
                else if (note_sel < STEP4_FROM)
                begin
                    stride = 2;
                end
                else
                begin
                    stride = 4;
                end
                wave_idx_next = wave_idx_next + stride;
                if (wave_idx_next >= TABLE_SIZE)
                begin
                    wave_idx_next = 0;
                end
                wave_steps++;
            end
            else
            begin
                tone_count = tone_count + 16'd1;
            end
            pwm_count = pwm_count + 8'd1;
            if (pwm_count == 8'd0)
            begin
                duty_level = wave_level(shark, wave_idx % 64);
                duty_loads++;
            end
        end
    endtask

    function automatic result_t current_outputs();
        result_t r;
        r.pwm_high = playing && (pwm_count <= duty_level);
        r.duty     = duty_level;
        r.led_on   = led_lit;
        r.sounding = playing;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_prediction();
            expected_outputs.delete();
            mismatches    = 0;
            outstanding   = 0;
            results_seen  = 0;
            wave_steps    = 0;
            duty_loads    = 0;
            drain_checked = 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_outputs.size() == 0)
                begin
                    flag($sformatf("result %0d arrived with nothing expected", results_seen));
                end
                else
                begin
                    result_t want;
                    want = expected_outputs.pop_front();
                    if (result.pwm_high !== want.pwm_high)
                        flag($sformatf("result %0d pwm_high %b, expected %b",
                                       results_seen, result.pwm_high, want.pwm_high));
                    if (result.duty !== want.duty)
                        flag($sformatf("result %0d duty %0d, expected %0d",
                                       results_seen, result.duty, want.duty));
                    if (result.led_on !== want.led_on)
                        flag($sformatf("result %0d led_on %b, expected %b",
                                       results_seen, result.led_on, want.led_on));
                    if (result.sounding !== want.sounding)
                        flag($sformatf("result %0d sounding %b, expected %b",
                                       results_seen, result.sounding, want.sounding));
                end
                results_seen++;
            end
            if (item_valid && item_ready)
            begin
                if (item.req_type == REQ_BYTE)
                begin
                    parse_midi(item.midi_byte, item.frame_error);
                end
                else
                begin
                    run_tick(item.wave_select);
                end
                expected_outputs.push_back(current_outputs());
            end
            if (run_done && !drain_checked)
            begin
                drain_checked = 1'b1;
                if (expected_outputs.size() != 0)
                begin
                    flag($sformatf("%0d expected results never arrived", expected_outputs.size()));
                end
            end
            outstanding = expected_outputs.size();
        end
    end

endmodule

// ===== tb/midi_wavetable_tone_generator_unit_tb.sv =====
`timescale 1ns / 1ps

module midi_wavetable_tone_generator_unit_tb;
    import mwtg_pkg::*;

    localparam int TABLE_SIZE   = 64;
    localparam int NOTE_COUNT   = 74;
    localparam int RANDOM_BEATS = 1050;

    logic    clk;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;
    logic    run_done     = 1'b0;

    int mismatches;
    int outstanding;
    int results_seen;
    int wave_steps;
    int duty_loads;

    int   beats_sent    = 0;
    int   item_gap_pct  = 10;
    int   ready_gap_pct = 10;
    logic shark_pin     = 1'b0;

    midi_wavetable_tone_generator_unit #(
        .TABLE_SIZE (TABLE_SIZE),
        .NOTE_COUNT (NOTE_COUNT)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    mwtg_tone_checker #(
        .TABLE_SIZE (TABLE_SIZE),
        .NOTE_COUNT (NOTE_COUNT)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .run_done     (run_done),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .wave_steps   (wave_steps),
        .duty_loads   (duty_loads)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk)
    begin
        result_ready <= rst_n && ($urandom_range(99) >= ready_gap_pct);
    end

    initial
    begin
        #10_000_000;
        $display("timeout");
        $display("FAILURE");
        $finish;
    end

    // one beat on the item channel; returns at the accepting edge
    task automatic send_item(input item_t beat);
        @(negedge clk);
        while ($urandom_range(99) < item_gap_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        beats_sent++;
    endtask

    task automatic play_byte(input logic [7:0] b, input logic ferr);
        item_t beat;
        beat.req_type    = REQ_BYTE;
        beat.midi_byte   = b;
        beat.frame_error = ferr;
        beat.wave_select = 1'($urandom_range(1));
        send_item(beat);
    endtask

    task automatic play_ticks(input int n);
        item_t beat;
        repeat (n)
        begin
            if ($urandom_range(49) == 0)
            begin
                shark_pin = ~shark_pin;
            end
            beat.req_type    = REQ_TICK;
            beat.midi_byte   = 8'($urandom_range(255));
            beat.frame_error = 1'($urandom_range(1));
            beat.wave_select = shark_pin;
            send_item(beat);
        end
    endtask

    task automatic play_note_on(input logic [7:0] note, input logic [7:0] vel);
        play_byte({STAT_ON, 4'($urandom_range(15))}, 1'b0);
        play_byte(note, $urandom_range(9) == 0);
        play_byte(vel, $urandom_range(9) == 0);
    endtask

    initial
    begin
        int          random_goal;
        int          pick;
        logic [7:0]  note;
        int          waited;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ticks while stopped, ignored status bytes, stray data bytes
        play_ticks(3);
        play_byte({STAT_ON, 4'h0}, 1'b1);
        play_byte(8'hf0, 1'b0);
        play_byte(8'ha5, 1'b0);
        play_byte(8'h00, 1'b0);
        play_byte(8'hff, 1'b0);
        // lowest note, frame error on the velocity beat
        play_byte({STAT_ON, 4'hf}, 1'b0);
        play_byte(NOTE_BASE, 1'b0);
        play_byte(8'h7f, 1'b1);
        play_ticks(300);
        // below the note range wraps to an invalid index
        play_note_on(NOTE_BASE - 8'd1, 8'h40);
        play_note_on(NOTE_BASE + 8'(NOTE_COUNT - 1), 8'h00);
        play_ticks(20);
        play_note_on(NOTE_BASE + 8'(NOTE_COUNT), 8'h7f);
        play_byte({STAT_OFF, 4'hf}, 1'b0);
        play_byte(8'h3c, 1'b1);
        play_byte(8'h40, 1'b1);
        play_byte({STAT_OFF, 4'h3}, 1'b1);
        // status bytes taken as data
        play_byte({STAT_ON, 4'h0}, 1'b0);
        play_byte({STAT_ON, 4'h0}, 1'b0);
        play_byte({STAT_OFF, 4'h0}, 1'b0);
        // retune downward mid-count: counter carries on above the new period
        play_note_on(NOTE_BASE, 8'h50);
        play_ticks(400);
        play_note_on(NOTE_BASE + 8'(NOTE_COUNT - 1), 8'h50);
        play_ticks(100);

        random_goal = beats_sent + RANDOM_BEATS;
        while (beats_sent < random_goal)
        begin
            if (random_goal - beats_sent < 800 && random_goal - beats_sent > 300)
            begin
                item_gap_pct  = 0;
                ready_gap_pct = 0;
            end
            else
            begin
                item_gap_pct  = 10;
                ready_gap_pct = 10;
            end
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                if ($urandom_range(99) < 85)
                    note = NOTE_BASE + 8'($urandom_range(NOTE_COUNT - 1));
                else
                    note = 8'($urandom_range(255));
                play_note_on(note, 8'($urandom_range(255)));
            end
            else if (pick < 70)
            begin
                play_byte({STAT_OFF, 4'($urandom_range(15))}, $urandom_range(19) == 0);
                play_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
                play_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
            end
            else if (pick < 85)
            begin
                play_byte(8'($urandom_range(255)), $urandom_range(4) == 0);
            end
            else
            begin
                // cut-short message: a second status byte lands in a data slot
                play_byte({3'b100, 1'($urandom_range(1)), 4'($urandom_range(15))}, 1'b0);
                play_byte({4'($urandom_range(8, 15)), 4'($urandom_range(15))},
                          1'($urandom_range(1)));
            end
            pick = $urandom_range(99);
            if (pick < 10)
                play_ticks($urandom_range(150, 500));
            else if (pick < 50)
                play_ticks($urandom_range(1, 24));
        end

        @(negedge clk);
        item_valid <= 1'b0;
        waited = 0;
        while (outstanding != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        run_done <= 1'b1;
        repeat (2) @(posedge clk);

        $display("covered %0d beats and %0d results, including a downward retune mid-count",
                 beats_sent, results_seen);
        $display("tone generator stepped the wave %0d times and reloaded the duty %0d times",
                 wave_steps, duty_loads);
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
